// File: rtl/core/rcfp_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame parser.
// Used by the controller, the datapath and the top level; depends on nothing.
package rcfp_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int CH_IDX_W     = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
    localparam int POS_W        = $clog2(4 + 2 * MAX_CHANNELS + 1);

    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [7:0]  VENDOR_RESET = 8'd168;

    localparam int APB_ADDR_W = 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_VENDOR = 2'd0;

    typedef enum logic [1:0] {
        KIND_CHANNEL    = 2'd0,
        KIND_CRC_BAD    = 2'd1,
        KIND_HEADER_BAD = 2'd2
    } rcfp_kind_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic commit;
        logic load_err;
        logic flush_clear;
        logic flush_inc;
        logic load_chan;
    } rcfp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic err;
        logic flush_go;
        logic flush_last;
        logic out_free;
    } rcfp_stat_t;

    // One byte of CRC-16, MSB first, no reflection.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/rcfp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module rcfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/rcfp_ctrl.sv
// Controller state machine: byte intake, parse commit and the channel flush.
// Depends on rcfp_pkg for the command and status structs.
module rcfp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rcfp_pkg::rcfp_stat_t stat,
    output rcfp_pkg::rcfp_cmd_t  cmd
);
    import rcfp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE      = 4'b0001,
        S_PARSE     = 4'b0010,
        S_FLUSH_RD  = 4'b0100,
        S_FLUSH_OUT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid) begin
                    state_next = S_PARSE;
                end
            end
            S_PARSE: begin
                // An error word needs the output register; anything else commits at once.
                if (!stat.err || stat.out_free) begin
                    cmd.commit   = 1'b1;
                    cmd.load_err = stat.err;
                    if (stat.flush_go) begin
                        cmd.flush_clear = 1'b1;
                        state_next      = S_FLUSH_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FLUSH_RD: begin
                state_next = S_FLUSH_OUT;
            end
            S_FLUSH_OUT: begin
                if (stat.out_free) begin
                    cmd.load_chan = 1'b1;
                    if (stat.flush_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.flush_inc = 1'b1;
                        state_next    = S_FLUSH_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/rcfp_datapath.sv
// Datapath: byte register, frame position, running CRC, header fields, the
// channel store RAM and the output register. Depends on rcfp_pkg and rcfp_ram.
module rcfp_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           in_byte,
    input  logic                 in_start,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    output logic [7:0]           vendor,
    input  rcfp_pkg::rcfp_cmd_t  cmd,
    output rcfp_pkg::rcfp_stat_t stat,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [1:0]           out_kind,
    output logic [4:0]           out_index,
    output logic [15:0]          out_value,
    output logic                 out_failsafe,
    output logic [5:0]           out_total,
    output logic                 out_last
);
    import rcfp_pkg::*;

    logic [7:0]          vendor_reg, vendor_next;
    logic [7:0]          byte_reg, byte_next;
    logic                start_reg, start_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [15:0]         crc_reg, crc_next;
    logic [7:0]          status_reg, status_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [7:0]          held_reg, held_next;
    logic [CH_IDX_W-1:0] flush_idx_reg, flush_idx_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_kind_reg, out_kind_next;
    logic [4:0]          out_index_reg, out_index_next;
    logic [15:0]         out_value_reg, out_value_next;
    logic                out_failsafe_reg, out_failsafe_next;
    logic [5:0]          out_total_reg, out_total_next;
    logic                out_last_reg, out_last_next;

    logic [15:0]         crc_fed;
    logic [POS_W-1:0]    data_end;
    logic [POS_W-1:0]    offset;
    logic                ram_we;
    logic [CH_IDX_W-1:0] ram_waddr;
    logic [15:0]         ram_rdata;
    logic                err;
    logic                flush_go;

    // A start byte seeds the CRC from zero.
    assign crc_fed  = crc_feed(start_reg ? 16'h0000 : crc_reg, byte_reg);
    assign data_end = POS_W'(3) + POS_W'({n_reg, 1'b0});
    assign offset   = pos_reg - POS_W'(3);

    // Decode of the held byte against the frame position.
    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        status_next = status_reg;
        n_next      = n_reg;
        held_next   = held_reg;
        err         = 1'b0;
        flush_go    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = offset[CH_IDX_W:1];
        if (start_reg) begin
            if (byte_reg != vendor_reg) begin
                err      = 1'b1;
                pos_next = '0;
            end else begin
                crc_next = crc_fed;
                pos_next = POS_W'(1);
            end
        end else if (pos_reg == '0) begin
            pos_next = '0;
        end else if (pos_reg == POS_W'(1)) begin
            status_next = byte_reg;
            crc_next    = crc_fed;
            pos_next    = POS_W'(2);
        end else if (pos_reg == POS_W'(2)) begin
            if (byte_reg < 8'd2 || byte_reg > 8'(MAX_CHANNELS)) begin
                err      = 1'b1;
                pos_next = '0;
            end else begin
                n_next   = byte_reg[CNT_W-1:0];
                crc_next = crc_fed;
                pos_next = POS_W'(3);
            end
        end else if (pos_reg < data_end) begin
            crc_next = crc_fed;
            if (!offset[0]) begin
                held_next = byte_reg;
            end else begin
                ram_we = cmd.commit;
            end
            pos_next = pos_reg + POS_W'(1);
        end else if (pos_reg == data_end) begin
            held_next = byte_reg;
            pos_next  = pos_reg + POS_W'(1);
        end else begin
            pos_next = '0;
            if ({held_reg, byte_reg} != crc_reg) begin
                err = 1'b1;
            end else begin
                flush_go = 1'b1;
            end
        end
    end

    assign stat.err        = err;
    assign stat.flush_go   = flush_go;
    assign stat.flush_last = (CNT_W'(flush_idx_reg) + CNT_W'(1)) == n_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    rcfp_ram #(
        .WIDTH(16),
        .DEPTH(MAX_CHANNELS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({held_reg, byte_reg}),
        .raddr (flush_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        vendor_next       = cfg_we ? cfg_wdata : vendor_reg;
        byte_next         = cmd.capture ? in_byte : byte_reg;
        start_next        = cmd.capture ? in_start : start_reg;
        flush_idx_next    = flush_idx_reg;
        if (cmd.flush_clear) begin
            flush_idx_next = '0;
        end else if (cmd.flush_inc) begin
            flush_idx_next = flush_idx_reg + CH_IDX_W'(1);
        end

        out_valid_next    = out_valid_reg && !out_ready;
        out_kind_next     = out_kind_reg;
        out_index_next    = out_index_reg;
        out_value_next    = out_value_reg;
        out_failsafe_next = out_failsafe_reg;
        out_total_next    = out_total_reg;
        out_last_next     = out_last_reg;
        if (cmd.load_err) begin
            out_valid_next    = 1'b1;
            out_kind_next     = (start_reg || pos_reg == POS_W'(2)) ? KIND_HEADER_BAD
                                                                    : KIND_CRC_BAD;
            out_index_next    = '0;
            out_value_next    = '0;
            out_failsafe_next = 1'b0;
            out_total_next    = '0;
            out_last_next     = 1'b1;
        end else if (cmd.load_chan) begin
            out_valid_next    = 1'b1;
            out_kind_next     = KIND_CHANNEL;
            out_index_next    = 5'(flush_idx_reg);
            out_value_next    = ram_rdata;
            out_failsafe_next = status_reg[7];
            out_total_next    = 6'(n_reg);
            out_last_next     = stat.flush_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vendor_reg    <= VENDOR_RESET;
            pos_reg       <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            vendor_reg    <= vendor_next;
            out_valid_reg <= out_valid_next;
            if (cmd.commit) begin
                pos_reg <= pos_next;
                crc_reg <= crc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg         <= byte_next;
        start_reg        <= start_next;
        flush_idx_reg    <= flush_idx_next;
        out_kind_reg     <= out_kind_next;
        out_index_reg    <= out_index_next;
        out_value_reg    <= out_value_next;
        out_failsafe_reg <= out_failsafe_next;
        out_total_reg    <= out_total_next;
        out_last_reg     <= out_last_next;
        if (cmd.commit) begin
            status_reg <= status_next;
            n_reg      <= n_next;
            held_reg   <= held_next;
        end
    end

    assign vendor       = vendor_reg;
    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_index    = out_index_reg;
    assign out_value    = out_value_reg;
    assign out_failsafe = out_failsafe_reg;
    assign out_total    = out_total_reg;
    assign out_last     = out_last_reg;

endmodule

// File: rtl/core/rc_receiver_frame_parser_crc16.sv
// Receiver frame parser with CRC-16 check, top level.
// Bytes enter on the s_ stream, one word per byte; s_tuser marks the first
// byte after an idle gap, which is taken as the vendor byte of a new frame.
// Frame: vendor, status, channel count N, N big-endian channel words, then a
// big-endian CRC-16 (0x1021, initial 0) over header and data.
// Results leave on the m_ stream: one word per channel after a good CRC,
// else a single error word (m_tuser gives the kind); m_tlast ends a frame.
// Each byte is accepted in S_IDLE and decoded in S_PARSE against the frame
// position, updating the running CRC and writing the channel store; no new
// byte is accepted before that decode commits. An error word enters the
// output register with its commit. After a good CRC the store is read back
// channel by channel via S_FLUSH_RD and S_FLUSH_OUT; no byte is accepted meanwhile.
// The output register decouples the sides: a byte is accepted while a word
// waits; only a byte that must emit, or the flush, waits for m_tready.
// A synchronous reset clears the position (hunting for a frame start), the
// output valid and sets the vendor register to 168; the channel store is
// not cleared, every entry being written before it is read. The vendor register
// sits at APB address 0 and is written only when idle, a user's rule that the block
// does not enforce. Depends on rcfp_pkg, rcfp_ctrl, rcfp_datapath and rcfp_ram.
module rc_receiver_frame_parser_crc16 (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [7:0] rx_byte
    input  logic                              s_tuser,  // [0] frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [4:0] channel_index, [20:5] channel_value, [21] failsafe,
    // [27:22] channel_total, [31:28] zero
    output logic [31:0]                       m_tdata,
    output logic [1:0]                        m_tuser,  // [1:0] result_kind
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rcfp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import rcfp_pkg::*;

    rcfp_cmd_t   cmd;
    rcfp_stat_t  stat;
    logic        cfg_we;
    logic [7:0]  vendor;
    logic [4:0]  out_index;
    logic [15:0] out_value;
    logic        out_failsafe;
    logic [5:0]  out_total;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == ADDR_VENDOR);
    assign prdata = (paddr == ADDR_VENDOR) ? {24'h000000, vendor} : 32'h00000000;

    rcfp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rcfp_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_byte      (s_tdata),
        .in_start     (s_tuser),
        .cfg_we       (cfg_we),
        .cfg_wdata    (pwdata[7:0]),
        .vendor       (vendor),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_kind     (m_tuser),
        .out_index    (out_index),
        .out_value    (out_value),
        .out_failsafe (out_failsafe),
        .out_total    (out_total),
        .out_last     (m_tlast)
    );

    assign m_tdata = {4'h0, out_total, out_failsafe, out_value, out_index};

endmodule

// File: bench/rc_receiver_frame_parser_crc16_tb.sv
// Self-checking bench for the receiver frame parser: frames, broken frames and noise
// go in on the byte stream, and a local parser model predicts every result word.
// Depends on rcfp_pkg and the rc_receiver_frame_parser_crc16 top level.
module rc_receiver_frame_parser_crc16_tb;
    import rcfp_pkg::*;

    localparam int DRAIN_CYCLES    = 12;
    localparam int ITEMS_PER_PHASE = 108;
    localparam int NUM_PHASES      = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } rx_item_t;

    typedef struct packed {
        rcfp_kind_t  kind;
        logic [4:0]  index;
        logic [15:0] value;
        logic        failsafe;
        logic [5:0]  total;
        logic        last;
    } parse_result_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_CRC,
        FLAW_CUT
    } frame_flaw_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;  // [7:0] rx_byte
    logic                  s_tuser  = 1'b0;   // [0] frame_start
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [4:0] channel_index, [20:5] channel_value, [21] failsafe,
    // [27:22] channel_total, [31:28] zero
    logic [31:0]           m_tdata;
    logic [1:0]            m_tuser;           // [1:0] result_kind
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = 32'h0;
    logic [31:0]           prdata;
    logic                  pready;

    rx_item_t      byte_queue[$];
    parse_result_t frame_results[$];
    rx_item_t      drv_next;

    int err_count       = 0;
    int items_sent      = 0;
    int channel_words   = 0;
    int crc_errors      = 0;
    int header_errors   = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    // Parser model state.
    logic [7:0]  cfg_vendor = VENDOR_RESET;
    int unsigned pp_pos     = 0;
    logic [15:0] pp_crc     = 16'h0000;
    logic [7:0]  pp_status  = 8'h00;
    logic [5:0]  pp_count   = 6'd0;
    logic [7:0]  pp_high    = 8'h00;
    logic [15:0] pp_store [MAX_CHANNELS];

    rc_receiver_frame_parser_crc16 DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s: got %0h, expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic push_error(input rcfp_kind_t kind);
        parse_result_t r;
        r.kind     = kind;
        r.index    = '0;
        r.value    = '0;
        r.failsafe = 1'b0;
        r.total    = '0;
        r.last     = 1'b1;
        frame_results.push_back(r);
    endtask

    // Advances the parser model by one accepted byte.
    task automatic parse_byte(input logic [7:0] b, input logic start);
        int unsigned   data_end;
        int unsigned   off;
        parse_result_t r;
        if (start) begin
            if (b != cfg_vendor) begin
                pp_pos = 0;
                push_error(KIND_HEADER_BAD);
            end else begin
                pp_crc = crc16_step(16'h0000, b);
                pp_pos = 1;
            end
        end else if (pp_pos == 1) begin
            pp_status = b;
            pp_crc    = crc16_step(pp_crc, b);
            pp_pos    = 2;
        end else if (pp_pos == 2) begin
            if (b < 2 || b > MAX_CHANNELS) begin
                pp_pos = 0;
                push_error(KIND_HEADER_BAD);
            end else begin
                pp_count = b[5:0];
                pp_crc   = crc16_step(pp_crc, b);
                pp_pos   = 3;
            end
        end else if (pp_pos != 0) begin
            data_end = 3 + 2 * pp_count;
            if (pp_pos < data_end) begin
                off    = pp_pos - 3;
                pp_crc = crc16_step(pp_crc, b);
                if (off % 2 == 0) begin
                    pp_high = b;
                end else begin
                    pp_store[off / 2] = {pp_high, b};
                end
                pp_pos++;
            end else if (pp_pos == data_end) begin
                pp_high = b;
                pp_pos++;
            end else begin
                pp_pos = 0;
                if ({pp_high, b} != pp_crc) begin
                    push_error(KIND_CRC_BAD);
                end else begin
                    for (int i = 0; i < pp_count; i++) begin
                        r.kind     = KIND_CHANNEL;
                        r.index    = i[4:0];
                        r.value    = pp_store[i];
                        r.failsafe = pp_status[7];
                        r.total    = pp_count;
                        r.last     = (i == pp_count - 1);
                        frame_results.push_back(r);
                    end
                end
            end
        end
    endtask

    task automatic send_item(input logic [7:0] data, input logic start);
        byte_queue.push_back({data, start});
        items_sent++;
    endtask

    // Queues one frame; a cut frame stops early so that the next start abandons it.
    task automatic add_frame(input int n, input logic [7:0] status, input frame_flaw_t flaw,
                             input bit extremes);
        rx_item_t    fb[$];
        logic [15:0] crc;
        logic [15:0] v;
        int          keep;
        fb.push_back({cfg_vendor, 1'b1});
        fb.push_back({status, 1'b0});
        fb.push_back({n[7:0], 1'b0});
        for (int i = 0; i < n; i++) begin
            v = extremes ? ((i % 2 != 0) ? 16'hFFFF : 16'h0000) : 16'($urandom);
            fb.push_back({v[15:8], 1'b0});
            fb.push_back({v[7:0], 1'b0});
        end
        crc = 16'h0000;
        foreach (fb[i]) crc = crc16_step(crc, fb[i].data);
        if (flaw == FLAW_CRC) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        fb.push_back({crc[15:8], 1'b0});
        fb.push_back({crc[7:0], 1'b0});
        keep = (flaw == FLAW_CUT) ? $urandom_range(1, fb.size() - 1) : fb.size();
        for (int i = 0; i < keep; i++) begin
            send_item(fb[i].data, fb[i].start);
        end
    endtask

    task automatic random_sequence();
        int pick;
        int n;
        int sel;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        n    = (sel < 15) ? 2 : (sel < 30) ? MAX_CHANNELS : $urandom_range(2, MAX_CHANNELS);
        if (pick < 58) begin
            add_frame(n, 8'($urandom), FLAW_NONE, $urandom_range(0, 9) == 0);
        end else if (pick < 70) begin
            add_frame(n, 8'($urandom), FLAW_CRC, 1'b0);
        end else if (pick < 78) begin
            add_frame(n, 8'($urandom), FLAW_CUT, 1'b0);
        end else if (pick < 84) begin
            send_item(cfg_vendor ^ 8'($urandom_range(1, 255)), 1'b1);
        end else if (pick < 90) begin
            send_item(cfg_vendor, 1'b1);
            send_item(8'($urandom), 1'b0);
            case ($urandom_range(0, 2))
                0: send_item(8'd0, 1'b0);
                1: send_item(8'd1, 1'b0);
                default: send_item(8'($urandom_range(MAX_CHANNELS + 1, 255)), 1'b0);
            endcase
        end else begin
            // Noise, ignored while the parser hunts; these bytes are not counted as items.
            repeat ($urandom_range(1, 4)) byte_queue.push_back({8'($urandom), 1'b0});
        end
    endtask

    // Waits until every queued byte is taken and every expected word has come back.
    task automatic wait_idle();
        while (byte_queue.size() != 0 || s_tvalid || frame_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_vendor(input logic [7:0] v);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_VENDOR;
        pwdata  <= {24'h0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        cfg_vendor = v;
        // Go straight into the read-back setup; psel stays high.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {24'h0, v}) report_mismatch("vendor register read-back", prdata, {24'h0, v});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) parse_byte(s_tdata, s_tuser);
            if (!s_tvalid || s_tready) begin
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    drv_next = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= drv_next.data;
                    s_tuser  <= drv_next.start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        parse_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tuser == KIND_CHANNEL) channel_words++;
            else if (m_tuser == KIND_CRC_BAD) crc_errors++;
            else header_errors++;
            if (frame_results.size() == 0) begin
                report_mismatch("result word with nothing expected", m_tdata, 32'h0);
            end else begin
                want = frame_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("result_kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[4:0] !== want.index)
                    report_mismatch("channel_index", 32'(m_tdata[4:0]), 32'(want.index));
                if (m_tdata[20:5] !== want.value)
                    report_mismatch("channel_value", 32'(m_tdata[20:5]), 32'(want.value));
                if (m_tdata[21] !== want.failsafe)
                    report_mismatch("failsafe", 32'(m_tdata[21]), 32'(want.failsafe));
                if (m_tdata[27:22] !== want.total)
                    report_mismatch("channel_total", 32'(m_tdata[27:22]), 32'(want.total));
                if (m_tdata[31:28] !== 4'h0)
                    report_mismatch("tdata padding", 32'(m_tdata[31:28]), 32'h0);
                if (m_tlast !== want.last)
                    report_mismatch("last_of_frame", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    initial begin
        int phase_start;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle();
                case (phase)
                    1: write_vendor(8'h00);
                    2: write_vendor(8'hFF);
                    default: write_vendor(8'($urandom_range(1, 254)));
                endcase
            end
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin sender_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            phase_start = items_sent;
            if (phase == 0) begin
                // Ignored while hunting, then the shortest frame with failsafe and
                // extreme words, a wrong vendor, counts just out of range, a bad CRC.
                byte_queue.push_back({8'h5A, 1'b0});
                add_frame(2, 8'h80, FLAW_NONE, 1'b1);
                send_item(cfg_vendor ^ 8'hFF, 1'b1);
                send_item(cfg_vendor, 1'b1);
                send_item(8'h00, 1'b0);
                send_item(8'd1, 1'b0);
                send_item(cfg_vendor, 1'b1);
                send_item(8'hFF, 1'b0);
                send_item(8'(MAX_CHANNELS + 1), 1'b0);
                add_frame(2, 8'h7F, FLAW_CRC, 1'b0);
            end
            while (items_sent - phase_start < ITEMS_PER_PHASE) random_sequence();
        end
        wait_idle();
        while (frame_results.size() != 0) begin
            report_mismatch("expected word never arrived", 32'h0,
                            32'(frame_results[0].value));
            void'(frame_results.pop_front());
        end
        $display("Sent %0d bytes over %0d idle and vendor settings.", items_sent, NUM_PHASES);
        $display("Checked %0d channel words, %0d CRC errors and %0d header errors.",
                 channel_words, crc_errors, header_errors);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
